[design/sfcm_pkg.sv]
// Package for the sensor value false-colour map.
// Holds the reading kinds, segment codes, stage records and fixed-point constants.
// No dependencies.
package sfcm_pkg;

	localparam logic [1:0] CMD_TEMP   = 2'd0;
	localparam logic [1:0] CMD_HUMID  = 2'd1;
	localparam logic [1:0] CMD_PRESS  = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		KIND_DIRECT,
		KIND_DIV,
		KIND_WHITE,
		KIND_BLACK
	} kind_t;

	typedef enum logic [3:0] {
		SEG_CONST,
		SEG_L0,
		SEG_L1,
		SEG_L2,
		SEG_L3,
		SEG_L4,
		SEG_L5,
		SEG_L6,
		SEG_L7,
		SEG_L8,
		SEG_L9,
		SEG_L10,
		SEG_L11
	} seg_t;

	localparam int RECIP_SHIFT = 24;
	localparam logic [20:0] RECIP_10 = 21'(((1 << RECIP_SHIFT) + 10 - 1) / 10);
	localparam logic [20:0] RECIP_21 = 21'(((1 << RECIP_SHIFT) + 21 - 1) / 21);

	localparam int TERM_SHIFT = 16;
	localparam logic [18:0] M_108_50  = 19'((108 * 65536 + 50 - 1) / 50);
	localparam logic [18:0] M_107_50  = 19'((107 * 65536 + 50 - 1) / 50);
	localparam logic [18:0] M_235_50  = 19'((235 * 65536 + 50 - 1) / 50);
	localparam logic [18:0] M_107_100 = 19'((107 * 65536 + 100 - 1) / 100);
	localparam logic [18:0] M_108_100 = 19'((108 * 65536 + 100 - 1) / 100);

	typedef struct packed {
		kind_t              kind;
		logic               neg;
		logic [39:0]        prod;
		logic signed [15:0] v;
	} scale_t;

	typedef struct packed {
		seg_t       seg;
		logic [6:0] ofs;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} segm_t;

endpackage

[design/sfcm_scale.sv]
// First two stages: maps a reading onto the temperature scale numerator and
// multiplies by the reciprocal of the divisor. Depends on sfcm_pkg.
module sfcm_scale (
	input  logic                   clk,
	input  logic                   en_1,
	input  logic                   en_2,
	input  logic [1:0]             cmd,
	input  logic signed [15:0]     value_tenths,
	input  logic                   absent,
	output sfcm_pkg::scale_t       scale_s2
);
	import sfcm_pkg::*;

	logic signed [19:0] v_ext;
	logic signed [19:0] vp;
	logic signed [19:0] num;
	logic [18:0]        mag;
	logic [18:0]        bias;
	kind_t              kind;
	logic               div21;

	kind_t              kind_s1;
	logic               neg_s1;
	logic [18:0]        a_s1;
	logic               div21_s1;
	logic signed [15:0] v_s1;

	always_comb begin
		v_ext = 20'(value_tenths);
		vp    = (value_tenths < 16'sd1000) ? v_ext + 20'sd9900 : v_ext;
		num   = 20'sd0;
		bias  = 19'd0;
		div21 = 1'b0;
		kind  = KIND_BLACK;
		unique case (cmd)
			CMD_TEMP: begin
				kind = KIND_DIRECT;
			end
			CMD_HUMID: begin
				kind = KIND_DIV;
				num  = 20'sd4500 - v_ext * 20'sd6;
				bias = 19'd5;
			end
			CMD_PRESS: begin
				kind  = KIND_DIV;
				num   = vp * 20'sd10 - 20'sd99150;
				bias  = 19'd10;
				div21 = 1'b1;
			end
			default: kind = KIND_BLACK;
		endcase
		if (absent) begin
			kind = KIND_WHITE;
		end
		mag = num[19] ? 19'(-num) : num[18:0];
	end

	always_ff @(posedge clk) begin
		if (en_1) begin
			kind_s1  <= kind;
			neg_s1   <= num[19];
			a_s1     <= mag + bias;
			div21_s1 <= div21;
			v_s1     <= value_tenths;
		end
	end

	always_ff @(posedge clk) begin
		if (en_2) begin
			scale_s2.kind <= kind_s1;
			scale_s2.neg  <= neg_s1;
			scale_s2.prod <= 40'(a_s1) * 40'(div21_s1 ? RECIP_21 : RECIP_10);
			scale_s2.v    <= v_s1;
		end
	end

endmodule

[design/sfcm_segment.sv]
// Third stage: recovers the scale value t and picks its segment, offset and knot colour.
// Depends on sfcm_pkg.
module sfcm_segment (
	input  logic             clk,
	input  logic             en_3,
	input  sfcm_pkg::scale_t scale_s2,
	output sfcm_pkg::segm_t  segm_s3
);
	import sfcm_pkg::*;

	logic [15:0]        quot;
	logic signed [16:0] t;
	logic signed [16:0] diff;
	segm_t              nxt;

	always_comb begin
		quot = scale_s2.prod[RECIP_SHIFT +: 16];
		if (scale_s2.kind == KIND_DIRECT) begin
			t = 17'(scale_s2.v);
		end else if (scale_s2.neg) begin
			t = -$signed({1'b0, quot});
		end else begin
			t = $signed({1'b0, quot});
		end
		diff    = 17'sd0;
		nxt.seg = SEG_CONST;
		nxt.r   = 8'd0;
		nxt.g   = 8'd0;
		nxt.b   = 8'd0;
		if (t <= -17'sd200) begin
			nxt.seg = SEG_CONST;
		end else if (t < -17'sd150) begin
			nxt.seg = SEG_L0;  diff = t + 17'sd200;
		end else if (t == -17'sd150) begin
			nxt.r = 8'd128; nxt.b = 8'd128;
		end else if (t < -17'sd100) begin
			nxt.seg = SEG_L1;  diff = t + 17'sd150;
		end else if (t == -17'sd100) begin
			nxt.r = 8'd128; nxt.b = 8'd255;
		end else if (t < -17'sd50) begin
			nxt.seg = SEG_L2;  diff = t + 17'sd100;
		end else if (t == -17'sd50) begin
			nxt.b = 8'd255;
		end else if (t < 17'sd0) begin
			nxt.seg = SEG_L3;  diff = t + 17'sd50;
		end else if (t == 17'sd0) begin
			nxt.g = 8'd128; nxt.b = 8'd255;
		end else if (t < 17'sd50) begin
			nxt.seg = SEG_L4;  diff = t;
		end else if (t == 17'sd50) begin
			nxt.g = 8'd255;
		end else if (t < 17'sd100) begin
			nxt.seg = SEG_L5;  diff = t - 17'sd50;
		end else if (t == 17'sd100) begin
			nxt.r = 8'd255; nxt.g = 8'd255;
		end else if (t < 17'sd200) begin
			nxt.seg = SEG_L6;  diff = t - 17'sd100;
		end else if (t == 17'sd200) begin
			nxt.r = 8'd255; nxt.g = 8'd128;
		end else if (t < 17'sd300) begin
			nxt.seg = SEG_L7;  diff = t - 17'sd200;
		end else if (t == 17'sd300) begin
			nxt.r = 8'd255;
		end else if (t < 17'sd350) begin
			nxt.seg = SEG_L8;  diff = t - 17'sd300;
		end else if (t == 17'sd350) begin
			nxt.r = 8'd255; nxt.b = 8'd128;
		end else if (t < 17'sd400) begin
			nxt.seg = SEG_L9;  diff = t - 17'sd350;
		end else if (t == 17'sd400) begin
			nxt.r = 8'd255; nxt.b = 8'd255;
		end else if (t < 17'sd450) begin
			nxt.seg = SEG_L10; diff = t - 17'sd400;
		end else if (t == 17'sd450) begin
			nxt.r = 8'd128; nxt.b = 8'd128;
		end else if (t < 17'sd500) begin
			nxt.seg = SEG_L11; diff = t - 17'sd450;
		end
		if (scale_s2.kind == KIND_WHITE) begin
			nxt.seg = SEG_CONST;
			nxt.r   = 8'd255;
			nxt.g   = 8'd255;
			nxt.b   = 8'd255;
		end else if (scale_s2.kind == KIND_BLACK) begin
			nxt.seg = SEG_CONST;
			nxt.r   = 8'd0;
			nxt.g   = 8'd0;
			nxt.b   = 8'd0;
		end
		nxt.ofs = diff[6:0];
	end

	always_ff @(posedge clk) begin
		if (en_3) begin
			segm_s3 <= nxt;
		end
	end

endmodule

[design/sfcm_shade.sv]
// Fourth and fifth stages: scales the segment offset and assembles the colour.
// Depends on sfcm_pkg.
module sfcm_shade (
	input  logic            clk,
	input  logic            en_4,
	input  logic            en_5,
	input  sfcm_pkg::segm_t segm_s3,
	output logic [7:0]      red,
	output logic [7:0]      green,
	output logic [7:0]      blue
);
	import sfcm_pkg::*;

	logic [18:0] mul_a;
	logic [25:0] prod_a;
	logic [25:0] prod_b;

	segm_t       segm_s4;
	logic [8:0]  ta_s4;
	logic [8:0]  tb_s4;

	logic [9:0]  ta;
	logic [9:0]  tb;
	logic [9:0]  r_n;
	logic [9:0]  g_n;
	logic [9:0]  b_n;

	logic [7:0]  red_s5;
	logic [7:0]  green_s5;
	logic [7:0]  blue_s5;

	always_comb begin
		case (segm_s3.seg) inside
			SEG_L1, SEG_L4, SEG_L9, SEG_L10: mul_a = M_107_50;
			SEG_L5:                          mul_a = M_235_50;
			SEG_L6:                          mul_a = M_107_100;
			SEG_L7:                          mul_a = M_108_100;
			default:                         mul_a = M_108_50;
		endcase
		prod_a = 26'(segm_s3.ofs) * 26'(mul_a);
		prod_b = 26'(segm_s3.ofs) * 26'(M_235_50);
	end

	always_ff @(posedge clk) begin
		if (en_4) begin
			segm_s4 <= segm_s3;
			ta_s4   <= prod_a[TERM_SHIFT +: 9];
			tb_s4   <= prod_b[TERM_SHIFT +: 9];
		end
	end

	always_comb begin
		ta  = 10'(ta_s4);
		tb  = 10'(tb_s4);
		r_n = 10'(segm_s4.r);
		g_n = 10'(segm_s4.g);
		b_n = 10'(segm_s4.b);
		case (segm_s4.seg)
			SEG_L0: begin
				r_n = 10'd10 + ta;  g_n = 10'd0;   b_n = 10'd10 + ta;
			end
			SEG_L1: begin
				r_n = 10'd128;      g_n = 10'd0;   b_n = 10'd138 + ta;
			end
			SEG_L2: begin
				r_n = 10'd118 - ta; g_n = 10'd0;   b_n = 10'd255;
			end
			SEG_L3: begin
				r_n = 10'd0;        g_n = 10'd10 + ta;  b_n = 10'd255;
			end
			SEG_L4: begin
				r_n = 10'd0;        g_n = 10'd138 + ta; b_n = 10'd245 - tb;
			end
			SEG_L5: begin
				r_n = 10'd10 + ta;  g_n = 10'd255; b_n = 10'd0;
			end
			SEG_L6: begin
				r_n = 10'd255;      g_n = 10'd245 - ta; b_n = 10'd0;
			end
			SEG_L7: begin
				r_n = 10'd255;      g_n = 10'd118 - ta; b_n = 10'd0;
			end
			SEG_L8: begin
				r_n = 10'd255;      g_n = 10'd0;   b_n = 10'd10 + ta;
			end
			SEG_L9: begin
				r_n = 10'd255;      g_n = 10'd0;   b_n = 10'd138 + ta;
			end
			SEG_L10: begin
				r_n = 10'd245 - ta; g_n = 10'd0;   b_n = 10'd245 - ta;
			end
			SEG_L11: begin
				r_n = 10'd118 - ta; g_n = 10'd0;   b_n = 10'd118 - ta;
			end
			default: begin
				r_n = 10'(segm_s4.r);
				g_n = 10'(segm_s4.g);
				b_n = 10'(segm_s4.b);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en_5) begin
			red_s5   <= r_n[7:0];
			green_s5 <= g_n[7:0];
			blue_s5  <= b_n[7:0];
		end
	end

	assign red   = red_s5;
	assign green = green_s5;
	assign blue  = blue_s5;

endmodule

[design/sensor_value_false_color_map_unit.sv]
// Top level of the sensor value false-colour map.
// Instantiates sfcm_scale, sfcm_segment and sfcm_shade; depends on sfcm_pkg.
//
// Usage: each input item carries a reading (cmd, value_tenths, absent) and
// yields exactly one output item holding the colour (red, green, blue).
// Both channels use valid and ready; an item moves when both are high.
// The block is a five-stage pipeline: scale decode, reciprocal multiply,
// segment select, offset multiply and colour assembly in the output
// register. With the receiver ready, one item is taken every cycle; no
// unit is shared. Every stage stalls only while it holds an item and the
// stage after it cannot take one, so bubbles are squeezed out and in_ready
// stays high while the output register is empty. When the receiver holds
// out_ready low, the result stays on the output and up to four more items
// are still accepted before in_ready falls. Reset clears all valid bits;
// the pipeline is empty and ready straight after reset.
module sensor_value_false_color_map_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] value_tenths,
	input  logic               absent,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue
);
	import sfcm_pkg::*;

	logic     vld_s1;
	logic     vld_s2;
	logic     vld_s3;
	logic     vld_s4;
	logic     vld_s5;
	logic     en_1;
	logic     en_2;
	logic     en_3;
	logic     en_4;
	logic     en_5;
	scale_t   scale_s2;
	segm_t    segm_s3;

	assign en_5 = !vld_s5 || out_ready;
	assign en_4 = !vld_s4 || en_5;
	assign en_3 = !vld_s3 || en_4;
	assign en_2 = !vld_s2 || en_3;
	assign en_1 = !vld_s1 || en_2;

	assign in_ready  = en_1;
	assign out_valid = vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (en_1) vld_s1 <= in_valid;
			if (en_2) vld_s2 <= vld_s1;
			if (en_3) vld_s3 <= vld_s2;
			if (en_4) vld_s4 <= vld_s3;
			if (en_5) vld_s5 <= vld_s4;
		end
	end

	sfcm_scale u_scale (
		.clk          (clk),
		.en_1         (en_1),
		.en_2         (en_2),
		.cmd          (cmd),
		.value_tenths (value_tenths),
		.absent       (absent),
		.scale_s2     (scale_s2)
	);

	sfcm_segment u_segment (
		.clk      (clk),
		.en_3     (en_3),
		.scale_s2 (scale_s2),
		.segm_s3  (segm_s3)
	);

	sfcm_shade u_shade (
		.clk     (clk),
		.en_4    (en_4),
		.en_5    (en_5),
		.segm_s3 (segm_s3),
		.red     (red),
		.green   (green),
		.blue    (blue)
	);

endmodule

[design/sfcm_checker.sv]
// Port-level checks for the sensor value false-colour map, bound to the top level.
// Depends on the ports of sensor_value_false_color_map_unit and on sfcm_pkg.
module sfcm_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic signed [15:0] value_tenths,
	input  logic               absent,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [7:0]         red,
	input  logic [7:0]         green,
	input  logic [7:0]         blue
);
	import sfcm_pkg::*;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled although the output register can move");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(red) && $stable(green)
			&& $stable(blue)))
		else $error("stalled output item changed");

	a_white_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && absent) ##1 out_ready ##1 out_ready ##1 out_ready
			##1 out_ready |=> (out_valid && red == 8'd255 && green == 8'd255
			&& blue == 8'd255))
		else $error("missing reading did not give white after five stages");

	a_unused_black: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !absent && cmd == CMD_UNUSED) ##1 out_ready
			##1 out_ready ##1 out_ready ##1 out_ready |=> (out_valid && red == 8'd0
			&& green == 8'd0 && blue == 8'd0))
		else $error("unused reading kind did not give black");

endmodule

bind sensor_value_false_color_map_unit sfcm_checker u_sfcm_checker (.*);

[sim/testbench.sv]
// Self-checking testbench for the sensor value false-colour map.
// Predicts each colour from the reading and checks every output item in order.
// Depends on sfcm_pkg and sensor_value_false_color_map_unit.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import sfcm_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_ITEMS = 400;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} rgb_t;

	class colour_board;
		rgb_t pending[$];
		int mismatches;

		function new();
			mismatches = 0;
		endfunction

		static function rgb_t rgb(int r, int g, int b);
			rgb_t c;
			c.r = 8'(r);
			c.g = 8'(g);
			c.b = 8'(b);
			return c;
		endfunction

		static function int round_half(int n, int d);
			if (n >= 0)
				return (2 * n + d) / (2 * d);
			return -((-2 * n + d) / (2 * d));
		endfunction

		static function rgb_t predict_colour(logic [1:0] kind, logic signed [15:0] reading,
				logic missing);
			int v;
			int t;
			int a;
			v = int'(reading);
			if (missing)
				return rgb(255, 255, 255);
			case (kind)
				CMD_TEMP: t = v;
				CMD_HUMID: t = round_half(4500 - 6 * v, 10);
				CMD_PRESS: begin
					if (v < 1000)
						v = v + 9900;
					t = round_half(-3150 + 10 * (v - 9600), 21);
				end
				default: return rgb(0, 0, 0);
			endcase
			if (t <= -200) return rgb(0, 0, 0);
			if (t < -150) begin
				a = 10 + (t + 200) * 108 / 50;
				return rgb(a, 0, a);
			end
			if (t == -150) return rgb(128, 0, 128);
			if (t < -100) return rgb(128, 0, 138 + (t + 150) * 107 / 50);
			if (t == -100) return rgb(128, 0, 255);
			if (t < -50) return rgb(118 + (-100 - t) * 108 / 50, 0, 255);
			if (t == -50) return rgb(0, 0, 255);
			if (t < 0) return rgb(0, 10 + (t + 50) * 108 / 50, 255);
			if (t == 0) return rgb(0, 128, 255);
			if (t < 50) return rgb(0, 138 + t * 107 / 50, 245 - t * 235 / 50);
			if (t == 50) return rgb(0, 255, 0);
			if (t < 100) return rgb(10 + (t - 50) * 235 / 50, 255, 0);
			if (t == 100) return rgb(255, 255, 0);
			if (t < 200) return rgb(255, 245 + (100 - t) * 107 / 100, 0);
			if (t == 200) return rgb(255, 128, 0);
			if (t < 300) return rgb(255, 118 + (200 - t) * 108 / 100, 0);
			if (t == 300) return rgb(255, 0, 0);
			if (t < 350) return rgb(255, 0, 10 + (t - 300) * 108 / 50);
			if (t == 350) return rgb(255, 0, 128);
			if (t < 400) return rgb(255, 0, 138 + (t - 350) * 107 / 50);
			if (t == 400) return rgb(255, 0, 255);
			if (t < 450) begin
				a = 245 + (400 - t) * 107 / 50;
				return rgb(a, 0, a);
			end
			if (t == 450) return rgb(128, 0, 128);
			if (t < 500) begin
				a = 118 + (450 - t) * 108 / 50;
				return rgb(a, 0, a);
			end
			return rgb(0, 0, 0);
		endfunction

		function void note_reading(logic [1:0] kind, logic signed [15:0] reading,
				logic missing);
			pending.push_back(predict_colour(kind, reading, missing));
		endfunction

		function void check_colour(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			rgb_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Unexpected colour item (%0d,%0d,%0d) at %0t", r, g, b, $realtime);
				return;
			end
			want = pending.pop_front();
			if (r !== want.r || g !== want.g || b !== want.b) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("Colour mismatch at %0t: expected (%0d,%0d,%0d), got (%0d,%0d,%0d)",
						$realtime, want.r, want.g, want.b, r, g, b);
			end
		endfunction

		function int outstanding();
			return pending.size();
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic signed [15:0] value_tenths;
	logic               absent;
	logic               out_valid;
	logic               out_ready;
	logic [7:0]         red;
	logic [7:0]         green;
	logic [7:0]         blue;

	colour_board board = new();
	int idle_pct = 0;
	int stall_pct = 0;
	int items_taken = 0;
	logic holding = 1'b0;

	sensor_value_false_color_map_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.cmd          (cmd),
		.value_tenths (value_tenths),
		.absent       (absent),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.red          (red),
		.green        (green),
		.blue         (blue)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic offer_reading(input logic [1:0] kind, input int reading,
			input logic missing);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= kind;
		value_tenths <= 16'(reading);
		absent       <= missing;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		board.note_reading(kind, 16'(reading), missing);
		items_taken++;
	endtask

	// Most readings are aimed at the coloured part of the scale for their kind.
	task automatic offer_random_reading();
		int pick;
		logic [1:0] kind;
		int v;
		logic missing;
		pick = $urandom_range(99);
		kind = 2'($urandom_range(2));
		v = int'($signed(16'($urandom)));
		missing = 1'b0;
		if (pick < 6) begin
			missing = 1'b1;
			kind = 2'($urandom_range(3));
		end else if (pick < 10) begin
			kind = CMD_UNUSED;
		end else if (pick < 18) begin
		end else if (pick < 45) begin
			kind = CMD_TEMP;
			v = -220 + $urandom_range(740);
		end else if (pick < 65) begin
			kind = CMD_HUMID;
			v = -120 + $urandom_range(1240);
		end else if (pick < 82) begin
			kind = CMD_PRESS;
			v = 9400 + $urandom_range(1700);
		end else begin
			kind = CMD_PRESS;
			v = -500 + $urandom_range(1499);
		end
		offer_reading(kind, v, missing);
	endtask

	initial begin
		int knots[$];
		int idle_tbl[4];
		int stall_tbl[4];
		knots = {-32768, 32767, -200, -199, -150, -100, -50, -1, 0, 49, 50, 100,
			199, 200, 300, 350, 400, 449, 450, 499, 500};
		idle_tbl = '{0, 88, 0, 17};
		stall_tbl = '{0, 0, 88, 17};
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		cmd          = CMD_TEMP;
		value_tenths = '0;
		absent       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (knots[i])
			offer_reading(CMD_TEMP, knots[i], 1'b0);
		offer_reading(CMD_HUMID, 0, 1'b0);
		offer_reading(CMD_PRESS, 999, 1'b0);
		offer_reading(CMD_PRESS, 10132, 1'b0);
		offer_reading(CMD_UNUSED, 200, 1'b0);
		offer_reading(CMD_PRESS, -32768, 1'b1);

		for (int p = 0; p < 4; p++) begin
			idle_pct = idle_tbl[p];
			stall_pct = stall_tbl[p];
			repeat (PHASE_ITEMS)
				offer_random_reading();
		end
		in_valid <= 1'b0;

		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (board.mismatches == 0)
			$display("sensor_value_false_color_map_unit regression: pass");
		else
			$display("sensor_value_false_color_map_unit regression: fail");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				board.check_colour(red, green, blue);
			out_ready <= !holding && ($urandom_range(99) >= stall_pct);
		end
	end

	// A long hold-off on the output while the input keeps offering items.
	initial begin
		wait (items_taken >= 60);
		@(posedge clk);
		holding <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		holding <= 1'b0;
	end

	initial begin
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet);
				$display("sensor_value_false_color_map_unit regression: fail");
				$finish;
			end
		end
	end

endmodule
